[rtl/core/quaternion_slerp_core_assert.svh]
// assertion macros shared by the slerp core
`ifndef QUATERNION_SLERP_CORE_ASSERT_SVH
`define QUATERNION_SLERP_CORE_ASSERT_SVH
`ifndef ASSERT_OFF
`define SLERP_ASSERT_IMP(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("slerp core: same-cycle check failed");
`define SLERP_ASSERT_NXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("slerp core: next-cycle check failed");
`else
`define SLERP_ASSERT_IMP(label, clk, rst, a, b)
`define SLERP_ASSERT_NXT(label, clk, rst, a, b)
`endif
`endif

[rtl/core/qslerp_pkg.sv]
`timescale 1ns / 1ps
// types, constants and the arctangent table of the slerp core
package qslerp_pkg;
  localparam int CW = 16;
  localparam int FRAC = CW - 2;
  localparam int AFRAC = CW - 3;
  localparam int ONE = 1 << FRAC;
  localparam int PI_A = 25736;
  localparam int HALF_A = 12868;
  localparam int SQRT_STEPS = 31;
  localparam int DIV_STEPS = 31;
  localparam logic signed [33:0] HALFPI30 = 34'sd1686629713;
  localparam logic signed [33:0] KGAIN30 = 34'sd652032874;

  localparam logic [1:0] BLEND_IN = 2'd0;
  localparam logic [1:0] BLEND_LOW = 2'd1;
  localparam logic [1:0] BLEND_HIGH = 2'd2;

  typedef logic signed [CW-1:0] comp_t;

  typedef struct packed {
    comp_t start_x;
    comp_t start_y;
    comp_t start_z;
    comp_t start_w;
    comp_t end_x;
    comp_t end_y;
    comp_t end_z;
    comp_t end_w;
    comp_t blend;
  } slerp_in_t;

  typedef struct packed {
    comp_t out_x;
    comp_t out_y;
    comp_t out_z;
    comp_t out_w;
    logic  degenerate;
  } slerp_out_t;

  typedef struct packed {
    slerp_in_t  data;
    logic [1:0] cls;
  } slerp_job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_stat_t;

  // atan(2^-i) in q.30 radians
  function automatic logic signed [33:0] atan30(input int i);
    logic signed [33:0] v;
    case (i)
      0: v = 34'sh3243F6A8;
      1: v = 34'sh1DAC6705;
      2: v = 34'sh0FADBAFC;
      3: v = 34'sh07F56EA6;
      4: v = 34'sh03FEAB76;
      5: v = 34'sh01FFD55B;
      6: v = 34'sh00FFFAAA;
      7: v = 34'sh007FFF55;
      8: v = 34'sh003FFFEA;
      9: v = 34'sh001FFFFD;
      10: v = 34'sh000FFFFF;
      11: v = 34'sh0007FFFF;
      12: v = 34'sh0003FFFF;
      13: v = 34'sh0001FFFF;
      14: v = 34'sh0000FFFF;
      15: v = 34'sh00007FFF;
      16: v = 34'sh00003FFF;
      17: v = 34'sh00001FFF;
      18: v = 34'sh00000FFF;
      19: v = 34'sh000007FF;
      20: v = 34'sh000003FF;
      21: v = 34'sh000001FF;
      22: v = 34'sh000000FF;
      23: v = 34'sh0000007F;
      24: v = 34'sh0000003F;
      25: v = 34'sh0000001F;
      26: v = 34'sh0000000F;
      27: v = 34'sh00000008;
      28: v = 34'sh00000004;
      29: v = 34'sh00000002;
      30: v = 34'sh00000001;
      default: v = '0;
    endcase
    return v;
  endfunction
endpackage

[rtl/core/qslerp_stream_if.sv]
`timescale 1ns / 1ps
// valid/ready stream channel carrying one payload item
interface qslerp_stream_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     data;

  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

[rtl/core/qslerp_front.sv]
`timescale 1ns / 1ps
// front end: takes input transfers, classifies the blend range, pushes jobs
module qslerp_front import qslerp_pkg::*; (
  qslerp_stream_if.sink item,
  input  queue_stat_t   qstat,
  output logic          push,
  output slerp_job_t    job
);
  assign item.ready = !qstat.full;
  assign push = item.valid && !qstat.full;

  always_comb begin
    job.data = item.data;
    if (item.data.blend < 0) begin
      job.cls = BLEND_LOW;
    end else if (item.data.blend > CW'(ONE)) begin
      job.cls = BLEND_HIGH;
    end else begin
      job.cls = BLEND_IN;
    end
  end
endmodule

[rtl/core/qslerp_queue.sv]
`timescale 1ns / 1ps
// small job queue between the front end and the datapath
module qslerp_queue import qslerp_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  slerp_job_t  wdata,
  input  logic        pop,
  output slerp_job_t  rdata,
  output queue_stat_t stat
);
  localparam int AW = $clog2(DEPTH);

  slerp_job_t mem [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [AW:0] count;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10: count <= count + 1'b1;
        2'b01: count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  assign rdata = mem[rd_ptr];
  assign stat.full = (count == (AW + 1)'(DEPTH));
  assign stat.empty = (count == '0);
endmodule

[rtl/core/qslerp_back.sv]
`timescale 1ns / 1ps
// datapath: dot product, sqrt, acos and sine cordics, weight divide, blend
module qslerp_back import qslerp_pkg::*; #(
  parameter int STEPS = 16
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       job_valid,
  input  slerp_job_t job,
  output logic       pop,
  qslerp_stream_if.source result
);
  localparam int NS = (STEPS > 32) ? 32 : STEPS;
  localparam int S_SQ = 3;
  localparam int S_V0 = S_SQ + SQRT_STEPS;
  localparam int S_VEC = S_V0 + 1;
  localparam int S_TH = S_VEC + NS;
  localparam int S_TB = S_TH + 1;
  localparam int S_SP = S_TB + 1;
  localparam int S_SIN = S_SP + 1;
  localparam int S_CK = S_SIN + NS;
  localparam int S_DIV = S_CK + 1;
  localparam int S_W = S_DIV + DIV_STEPS;
  localparam int S_M = S_W + 1;
  localparam int S_O = S_M + 1;
  localparam int LAT = S_O + 1;
  localparam logic signed [33:0] DEG_LIM = 34'sd1 <<< (29 - FRAC);

  function automatic comp_t pick(input slerp_in_t d, input logic side, input logic [1:0] j);
    comp_t v;
    case ({side, j})
      3'b000: v = d.start_x;
      3'b001: v = d.start_y;
      3'b010: v = d.start_z;
      3'b011: v = d.start_w;
      3'b100: v = d.end_x;
      3'b101: v = d.end_y;
      3'b110: v = d.end_z;
      3'b111: v = d.end_w;
      default: v = '0;
    endcase
    return v;
  endfunction

  // reflect angles past a quarter turn back into the first quadrant
  function automatic logic signed [17:0] fold(input logic signed [17:0] p);
    return (p > 18'(HALF_A)) ? 18'(PI_A) - p : p;
  endfunction

  function automatic logic [31:0] absmag(input logic signed [33:0] v);
    logic signed [33:0] m;
    m = (v < 0) ? -v : v;
    return m[31:0];
  endfunction

  function automatic logic signed [31:0] wfix(input logic [30:0] q, input logic neg);
    logic signed [31:0] w;
    w = (q > 31'(1 << 30)) ? 32'sd1 <<< 30 : $signed({1'b0, q});
    return neg ? -w : w;
  endfunction

  function automatic comp_t rnd_sat(input logic signed [48:0] s);
    logic signed [48:0] r;
    r = (s + (49'sd1 <<< (FRAC - 1))) >>> FRAC;
    if (r > 49'(ONE)) begin
      return CW'(ONE);
    end else if (r < -49'(ONE)) begin
      return -CW'(ONE);
    end
    return r[CW-1:0];
  endfunction

  logic adv;
  logic vld [LAT];
  slerp_job_t pj [LAT];

  assign adv = !vld[LAT-1] || result.ready;
  assign pop = adv && job_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s < LAT; s++) vld[s] <= 1'b0;
    end else if (adv) begin
      vld[0] <= job_valid;
      for (int s = 1; s < LAT; s++) vld[s] <= vld[s-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pj[0] <= job;
      for (int s = 1; s < LAT; s++) pj[s] <= pj[s-1];
    end
  end

  // dot product
  logic signed [2*CW-1:0] prod [4];
  logic signed [33:0] dsum;
  logic signed [33:0] dround;
  logic signed [CW-1:0] dot;
  logic signed [CW-1:0] dot2;
  logic [28:0] msq;

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int j = 0; j < 4; j++) begin
        prod[j] <= pick(job.data, 1'b0, 2'(j)) * pick(job.data, 1'b1, 2'(j));
      end
    end
  end

  always_comb begin
    dsum = '0;
    for (int j = 0; j < 4; j++) begin
      dsum = dsum + $signed({{4{prod[j][2*CW-1]}}, prod[j][2*CW-1:2]});
    end
    dround = (dsum + (34'sd1 <<< (FRAC - 3))) >>> (FRAC - 2);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (dround > 34'(ONE)) begin
        dot <= CW'(ONE);
      end else if (dround < -34'(ONE)) begin
        dot <= -CW'(ONE);
      end else begin
        dot <= dround[CW-1:0];
      end
      // 1 - d^2 scaled to q.28
      msq <= 29'((32'sd1 <<< 28) - dot * dot);
      dot2 <= dot;
    end
  end

  // square root, one result bit per stage
  logic [31:0] sq_root [SQRT_STEPS];
  logic [33:0] sq_rem [SQRT_STEPS];
  logic [28:0] sq_m [SQRT_STEPS];
  logic signed [CW-1:0] sq_d [SQRT_STEPS];

  for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_sq
    logic [31:0] root_in;
    logic [33:0] rem_in;
    logic [28:0] m_in;
    logic signed [CW-1:0] d_in;
    logic [29:0] nhi;
    logic [1:0] pair;
    logic [33:0] rem2;
    logic [33:0] trial;

    if (j == 0) begin : g_first
      assign root_in = '0;
      assign rem_in = '0;
      assign m_in = msq;
      assign d_in = dot2;
    end else begin : g_next
      assign root_in = sq_root[j-1];
      assign rem_in = sq_rem[j-1];
      assign m_in = sq_m[j-1];
      assign d_in = sq_d[j-1];
    end

    assign nhi = {1'b0, m_in};
    if (2 * j < 30) begin : g_pair
      assign pair = nhi[29-2*j -: 2];
    end else begin : g_zero
      assign pair = 2'b00;
    end
    assign rem2 = {rem_in[31:0], pair};
    assign trial = {root_in, 2'b01};

    always_ff @(posedge clk) begin
      if (adv) begin
        if (rem2 >= trial) begin
          sq_rem[j] <= rem2 - trial;
          sq_root[j] <= {root_in[30:0], 1'b1};
        end else begin
          sq_rem[j] <= rem2;
          sq_root[j] <= {root_in[30:0], 1'b0};
        end
        sq_m[j] <= m_in;
        sq_d[j] <= d_in;
      end
    end
  end

  // acos by vectoring on (d, sqrt(1 - d^2))
  logic signed [33:0] vx [NS+1];
  logic signed [33:0] vy [NS+1];
  logic signed [33:0] vz [NS+1];
  logic signed [33:0] d30;
  logic signed [33:0] s30;

  assign d30 = 34'(sq_d[SQRT_STEPS-1]) <<< (30 - FRAC);
  assign s30 = $signed({3'b000, sq_root[SQRT_STEPS-1][30:0]});

  always_ff @(posedge clk) begin
    if (adv) begin
      if (d30 < 0) begin
        vx[0] <= s30;
        vy[0] <= -d30;
        vz[0] <= HALFPI30;
      end else begin
        vx[0] <= d30;
        vy[0] <= s30;
        vz[0] <= '0;
      end
    end
  end

  for (genvar i = 0; i < NS; i++) begin : g_vec
    always_ff @(posedge clk) begin
      if (adv) begin
        if (vy[i] > 0) begin
          vx[i+1] <= vx[i] + (vy[i] >>> i);
          vy[i+1] <= vy[i] - (vx[i] >>> i);
          vz[i+1] <= vz[i] + atan30(i);
        end else begin
          vx[i+1] <= vx[i] - (vy[i] >>> i);
          vy[i+1] <= vy[i] + (vx[i] >>> i);
          vz[i+1] <= vz[i] - atan30(i);
        end
      end
    end
  end

  // theta0 and the two sub-angles
  logic signed [33:0] zr;
  logic [14:0] th0;
  logic signed [32:0] kth;
  logic signed [32:0] tbw;
  logic signed [17:0] ang [3];

  assign zr = (vz[NS] + (34'sd1 <<< (29 - AFRAC))) >>> (30 - AFRAC);

  always_ff @(posedge clk) begin
    if (adv) begin
      if (zr < 0) begin
        th0 <= '0;
      end else if (zr > 34'(PI_A)) begin
        th0 <= 15'(PI_A);
      end else begin
        th0 <= zr[14:0];
      end
    end
  end

  assign kth = pj[S_TB-1].data.blend * $signed({1'b0, th0});
  assign tbw = (kth + (33'sd1 <<< (FRAC - 1))) >>> FRAC;

  always_ff @(posedge clk) begin
    if (adv) begin
      ang[0] <= $signed({3'b000, th0});
      ang[1] <= $signed({3'b000, th0}) - tbw[17:0];
      ang[2] <= tbw[17:0];
    end
  end

  // three sine cordics: theta0, (1-k) theta0, k theta0
  logic signed [33:0] sx [3][NS+1];
  logic signed [33:0] sy [3][NS+1];
  logic signed [33:0] sz [3][NS+1];

  for (genvar l = 0; l < 3; l++) begin : g_lane
    always_ff @(posedge clk) begin
      if (adv) begin
        sx[l][0] <= KGAIN30;
        sy[l][0] <= '0;
        sz[l][0] <= 34'(fold(ang[l])) <<< (30 - AFRAC);
      end
    end

    for (genvar i = 0; i < NS; i++) begin : g_sin
      always_ff @(posedge clk) begin
        if (adv) begin
          if (sz[l][i] >= 0) begin
            sx[l][i+1] <= sx[l][i] - (sy[l][i] >>> i);
            sy[l][i+1] <= sy[l][i] + (sx[l][i] >>> i);
            sz[l][i+1] <= sz[l][i] - atan30(i);
          end else begin
            sx[l][i+1] <= sx[l][i] + (sy[l][i] >>> i);
            sy[l][i+1] <= sy[l][i] - (sx[l][i] >>> i);
            sz[l][i+1] <= sz[l][i] + atan30(i);
          end
        end
      end
    end
  end

  // weight division sin(t)*2^frac / sin(theta0), restoring, one bit per stage
  logic [62:0] dacc [2][DIV_STEPS+1];
  logic dneg [2][DIV_STEPS+1];
  logic [31:0] dvs [DIV_STEPS+1];
  logic ddeg [DIV_STEPS+1];

  always_ff @(posedge clk) begin
    if (adv) begin
      dvs[0] <= sy[0][NS][31:0];
      // sine of theta0 rounds to zero
      ddeg[0] <= sy[0][NS] < DEG_LIM;
    end
  end

  for (genvar l = 0; l < 2; l++) begin : g_dvd
    always_ff @(posedge clk) begin
      if (adv) begin
        dneg[l][0] <= sy[l+1][NS] < 0;
        dacc[l][0] <= {17'b0, absmag(sy[l+1][NS]), {FRAC{1'b0}}};
      end
    end
  end

  for (genvar t = 0; t < DIV_STEPS; t++) begin : g_div
    always_ff @(posedge clk) begin
      if (adv) begin
        dvs[t+1] <= dvs[t];
        ddeg[t+1] <= ddeg[t];
      end
    end
    for (genvar l = 0; l < 2; l++) begin : g_dl
      logic [32:0] top;
      logic [32:0] dif;
      assign top = dacc[l][t][62:30];
      assign dif = top - {1'b0, dvs[t]};
      always_ff @(posedge clk) begin
        if (adv) begin
          dneg[l][t+1] <= dneg[l][t];
          if (top >= {1'b0, dvs[t]}) begin
            dacc[l][t+1] <= {dif[31:0], dacc[l][t][29:0], 1'b1};
          end else begin
            dacc[l][t+1] <= {top[31:0], dacc[l][t][29:0], 1'b0};
          end
        end
      end
    end
  end

  // weight select, multiply, round and saturate
  logic signed [31:0] wp;
  logic signed [31:0] wq;
  logic wdeg;
  logic mdeg;
  logic signed [47:0] ma [4];
  logic signed [47:0] mb [4];
  slerp_out_t res;

  always_ff @(posedge clk) begin
    if (adv) begin
      wdeg <= 1'b0;
      case (pj[S_W-1].cls)
        BLEND_LOW: begin
          wp <= 32'(ONE);
          wq <= '0;
        end
        BLEND_HIGH: begin
          wp <= '0;
          wq <= 32'(ONE);
        end
        default: begin
          if (ddeg[DIV_STEPS]) begin
            wp <= 32'(ONE) - 32'(pj[S_W-1].data.blend);
            wq <= 32'(pj[S_W-1].data.blend);
            wdeg <= 1'b1;
          end else begin
            wp <= wfix(dacc[0][DIV_STEPS][30:0], dneg[0][DIV_STEPS]);
            wq <= wfix(dacc[1][DIV_STEPS][30:0], dneg[1][DIV_STEPS]);
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int j = 0; j < 4; j++) begin
        ma[j] <= wp * pick(pj[S_M-1].data, 1'b0, 2'(j));
        mb[j] <= wq * pick(pj[S_M-1].data, 1'b1, 2'(j));
      end
      mdeg <= wdeg;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res.out_x <= rnd_sat(49'(ma[0]) + 49'(mb[0]));
      res.out_y <= rnd_sat(49'(ma[1]) + 49'(mb[1]));
      res.out_z <= rnd_sat(49'(ma[2]) + 49'(mb[2]));
      res.out_w <= rnd_sat(49'(ma[3]) + 49'(mb[3]));
      res.degenerate <= mdeg;
    end
  end

  assign result.valid = vld[LAT-1];
  assign result.data = res;
endmodule

[rtl/core/quaternion_slerp_core.sv]
`timescale 1ns / 1ps
// Quaternion slerp core: takes one start/end/blend transfer per cycle while its job
// queue is not full and returns one interpolated quaternion per transfer, in order.
// The datapath is built from the 31-stage square root, the acos vectoring cordic,
// the three parallel sine cordics and the 31-stage weight divider, all of them
// fully pipelined behind one another. A job queue of QUEUE_DEPTH
// entries separates input acceptance from the datapath; the datapath stalls as a whole
// only while a finished result waits to be taken. Blends below zero or above one return
// the start or end quaternion; a zero angle sine gives the linear blend with degenerate
// set. All outputs saturate to [-1, 1] in Q2.14.
`include "quaternion_slerp_core_assert.svh"
module quaternion_slerp_core import qslerp_pkg::*; #(
  parameter int CORDIC_STEPS = 16,
  parameter int QUEUE_DEPTH = 4
) (
  input logic clk,
  input logic rst,
  qslerp_stream_if.sink item,
  qslerp_stream_if.source result
);
  logic push;
  logic pop;
  slerp_job_t wjob;
  slerp_job_t rjob;
  queue_stat_t qstat;

  qslerp_front u_front (
    .item (item),
    .qstat(qstat),
    .push (push),
    .job  (wjob)
  );

  qslerp_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .wdata(wjob),
    .pop  (pop),
    .rdata(rjob),
    .stat (qstat)
  );

  qslerp_back #(.STEPS(CORDIC_STEPS)) u_back (
    .clk      (clk),
    .rst      (rst),
    .job_valid(!qstat.empty),
    .job      (rjob),
    .pop      (pop),
    .result   (result)
  );

  `SLERP_ASSERT_IMP(a_full_blocks_input, clk, rst, qstat.full, !item.ready)
  `SLERP_ASSERT_IMP(a_pop_needs_job, clk, rst, pop, !qstat.empty)
  `SLERP_ASSERT_IMP(a_stall_holds_queue, clk, rst, result.valid && !result.ready, !pop)
  `SLERP_ASSERT_NXT(a_push_fills_queue, clk, rst, push && !pop, !qstat.empty)
endmodule
